### design/mbe_pkg.sv
package mbe_pkg;

  localparam int STEP_BITS = 5;
  localparam int STEP_REG_BITS = 31;
  localparam int CFG_INDEX_BITS = 2;

  localparam logic [CFG_INDEX_BITS-1:0] REG_X_STEP   = 2'd0;
  localparam logic [CFG_INDEX_BITS-1:0] REG_Y_STEP   = 2'd1;
  localparam logic [CFG_INDEX_BITS-1:0] REG_MAX_ITER = 2'd2;

  localparam logic [STEP_REG_BITS-1:0] X_STEP_RESET = 31'd1007894;
  localparam logic [STEP_REG_BITS-1:0] Y_STEP_RESET = 31'd1008313;
  localparam longint MAX_ITER_RESET = 524288;

  localparam logic [STEP_BITS-1:0] L_OUTSIDE = 5'd15;
  localparam logic [STEP_BITS-1:0] L_LOOP    = 5'd16;
  localparam logic [STEP_BITS-1:0] L_FINISH  = 5'd24;
  localparam logic [STEP_BITS-1:0] L_INSIDE  = 5'd25;

  typedef enum logic {
    ST_IDLE,
    ST_RUN
  } seq_state_t;

  typedef enum logic [3:0] {
    S_ONE,
    S_QUARTER,
    S_CR,
    S_CI,
    S_CI2,
    S_ZR,
    S_ZI,
    S_ZR2,
    S_ZI2,
    S_P,
    S_T
  } src_t;

  typedef enum logic [2:0] {
    D_CI2,
    D_ZR,
    D_ZI,
    D_ZR2,
    D_ZI2,
    D_P,
    D_T
  } dst_t;

  typedef enum logic [2:0] {
    C_NONE,
    C_ALWAYS,
    C_SUM_LT_SIXTEENTH,
    C_SUM_GE_FOUR,
    C_OUT_STRIP,
    C_WB_LT_QCI2,
    C_N_AT_MAX
  } cond_t;

  typedef struct packed {
    logic                 mul_en;
    src_t                 mul_a;
    src_t                 mul_b;
    logic                 wb_en;
    dst_t                 wb_dst;
    logic                 alu_en;
    logic                 alu_sub;
    src_t                 alu_a;
    src_t                 alu_b;
    dst_t                 alu_dst;
    logic                 cmul_en;
    logic                 cmul_y;
    logic                 cwb_en;
    logic                 cwb_y;
    logic                 zclr;
    logic                 ninc;
    cond_t                cond;
    logic [STEP_BITS-1:0] target;
    logic                 done;
    logic                 res_max;
  } ctrl_t;

  typedef struct packed {
    logic sum_lt_sixteenth;
    logic sum_ge_four;
    logic out_strip;
    logic wb_lt_qci2;
    logic n_at_max;
  } flags_t;

  function automatic ctrl_t ucode(logic [STEP_BITS-1:0] s);
    ctrl_t c;
    c = '0;
    unique case (s)
      5'd0: begin
        c.cmul_en = 1'b1;
      end
      5'd1: begin
        c.cwb_en = 1'b1;
        c.cmul_en = 1'b1; c.cmul_y = 1'b1;
      end
      5'd2: begin
        c.cwb_en = 1'b1; c.cwb_y = 1'b1;
      end
      5'd3: begin
        c.mul_en = 1'b1; c.mul_a = S_CI; c.mul_b = S_CI;
      end
      5'd4: begin
        c.wb_en = 1'b1; c.wb_dst = D_CI2;
        c.mul_en = 1'b1; c.mul_a = S_CR; c.mul_b = S_CR;
        c.alu_en = 1'b1; c.alu_a = S_CR; c.alu_b = S_ONE; c.alu_dst = D_T;
      end
      5'd5: begin
        c.wb_en = 1'b1; c.wb_dst = D_ZR2;
        c.mul_en = 1'b1; c.mul_a = S_T; c.mul_b = S_T;
      end
      5'd6: begin
        c.wb_en = 1'b1; c.wb_dst = D_ZI2;
        c.alu_a = S_ZR2; c.alu_b = S_CI2;
        c.cond = C_SUM_LT_SIXTEENTH; c.target = L_INSIDE;
      end
      5'd7: begin
        c.alu_a = S_ZI2; c.alu_b = S_CI2;
        c.cond = C_SUM_LT_SIXTEENTH; c.target = L_INSIDE;
      end
      5'd8: begin
        c.alu_en = 1'b1; c.alu_sub = 1'b1;
        c.alu_a = S_CR; c.alu_b = S_QUARTER; c.alu_dst = D_T;
        c.cond = C_OUT_STRIP; c.target = L_OUTSIDE;
      end
      5'd9: begin
        c.mul_en = 1'b1; c.mul_a = S_T; c.mul_b = S_T;
      end
      5'd10: begin
        c.wb_en = 1'b1; c.wb_dst = D_ZR2;
      end
      5'd11: begin
        c.alu_en = 1'b1; c.alu_a = S_ZR2; c.alu_b = S_CI2; c.alu_dst = D_P;
      end
      5'd12: begin
        c.alu_en = 1'b1; c.alu_a = S_P; c.alu_b = S_T; c.alu_dst = D_ZI;
      end
      5'd13: begin
        c.mul_en = 1'b1; c.mul_a = S_P; c.mul_b = S_ZI;
      end
      5'd14: begin
        c.wb_en = 1'b1; c.wb_dst = D_ZR2;
        c.cond = C_WB_LT_QCI2; c.target = L_INSIDE;
      end
      5'd15: begin
        c.zclr = 1'b1;
      end
      5'd16: begin
        c.mul_en = 1'b1; c.mul_a = S_ZR; c.mul_b = S_ZR;
        c.cond = C_N_AT_MAX; c.target = L_FINISH;
      end
      5'd17: begin
        c.wb_en = 1'b1; c.wb_dst = D_ZR2;
        c.mul_en = 1'b1; c.mul_a = S_ZI; c.mul_b = S_ZI;
      end
      5'd18: begin
        c.wb_en = 1'b1; c.wb_dst = D_ZI2;
        c.mul_en = 1'b1; c.mul_a = S_ZR; c.mul_b = S_ZI;
      end
      5'd19: begin
        c.wb_en = 1'b1; c.wb_dst = D_P;
        c.alu_a = S_ZR2; c.alu_b = S_ZI2;
        c.cond = C_SUM_GE_FOUR; c.target = L_FINISH;
      end
      5'd20: begin
        c.alu_en = 1'b1; c.alu_sub = 1'b1;
        c.alu_a = S_ZR2; c.alu_b = S_ZI2; c.alu_dst = D_T;
      end
      5'd21: begin
        c.alu_en = 1'b1; c.alu_a = S_T; c.alu_b = S_CR; c.alu_dst = D_ZR;
      end
      5'd22: begin
        c.alu_en = 1'b1; c.alu_a = S_P; c.alu_b = S_P; c.alu_dst = D_T;
      end
      5'd23: begin
        c.alu_en = 1'b1; c.alu_a = S_T; c.alu_b = S_CI; c.alu_dst = D_ZI;
        c.ninc = 1'b1;
        c.cond = C_ALWAYS; c.target = L_LOOP;
      end
      5'd24: begin
        c.done = 1'b1;
      end
      5'd25: begin
        c.done = 1'b1; c.res_max = 1'b1;
      end
      default: begin
        c.done = 1'b1;
      end
    endcase
    return c;
  endfunction

endpackage

### design/mandelbrot_escape_iteration.sv
// Mandelbrot escape-time unit. Pulse start with a pixel (column, row) while busy is low;
// busy stays high until the count is out, and done marks the one cycle in which
// iterations is valid. The result cannot be held off, so capture it on the done cycle.
// A new pixel may be started in that same cycle. A small microcode program drives a shared
// multiplier, a coordinate multiplier and one saturating adder, one step per cycle. Points in
// the disk at 0 are caught first, then points in the disk at -1, then points caught by
// the cardioid test, which runs only when the real part lies inside the cardioid strip.
// All other points run the eight-step loop body around the shared multiplier until
// the iteration cap is reached or the point escapes.
// Registers x_step, y_step and max_iter are written through cfg_write; the user must
// write them only while idle, as the block itself does not enforce it.
module mandelbrot_escape_iteration import mbe_pkg::*; #(
  parameter int INDEX_BITS = 12,
  parameter int FRAC_BITS = 28,
  parameter int ITER_BITS = 21
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                start,
  output logic                                busy,
  input  logic [INDEX_BITS-1:0]               column,
  input  logic [INDEX_BITS-1:0]               row,
  output logic                                done,
  output logic [ITER_BITS-1:0]                iterations,
  input  logic                                cfg_write,
  input  logic [CFG_INDEX_BITS-1:0]           cfg_index,
  input  logic [((ITER_BITS > STEP_REG_BITS) ? ITER_BITS : STEP_REG_BITS)-1:0] cfg_data
);

  logic [STEP_REG_BITS-1:0] x_step, y_step;
  logic [ITER_BITS-1:0]     max_iter;
  logic [ITER_BITS-1:0]     n;
  logic                     accept;
  ctrl_t                    ctrl;
  flags_t                   flags;

  assign accept = start && !busy;

  always_ff @(posedge clk) begin
    if (rst) begin
      x_step <= X_STEP_RESET;
      y_step <= Y_STEP_RESET;
      max_iter <= ITER_BITS'(MAX_ITER_RESET);
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_X_STEP:   x_step <= cfg_data[STEP_REG_BITS-1:0];
        REG_Y_STEP:   y_step <= cfg_data[STEP_REG_BITS-1:0];
        REG_MAX_ITER: max_iter <= cfg_data[ITER_BITS-1:0];
        default:      ;
      endcase
    end
  end

  mbe_sequencer u_seq (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .flags (flags),
    .ctrl  (ctrl),
    .busy  (busy)
  );

  mbe_datapath #(
    .INDEX_BITS (INDEX_BITS),
    .FRAC_BITS  (FRAC_BITS),
    .ITER_BITS  (ITER_BITS)
  ) u_dp (
    .clk      (clk),
    .accept   (accept),
    .column   (column),
    .row      (row),
    .x_step   (x_step),
    .y_step   (y_step),
    .max_iter (max_iter),
    .ctrl     (ctrl),
    .flags    (flags),
    .n        (n)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= ctrl.done;
    end
    if (ctrl.done) begin
      iterations <= ctrl.res_max ? max_iter : n;
    end
  end

  assert property (@(posedge clk) disable iff (rst) accept |=> (busy && !done))
    else $error("beat accepted but unit not busy");

  assert property (@(posedge clk) disable iff (rst) done |-> !busy)
    else $error("result shown while still busy");

  assert property (@(posedge clk) disable iff (rst) $fell(busy) |-> done)
    else $error("unit went idle without a result");

endmodule

### design/mbe_sequencer.sv
module mbe_sequencer import mbe_pkg::*; (
  input  logic   clk,
  input  logic   rst,
  input  logic   start,
  input  flags_t flags,
  output ctrl_t  ctrl,
  output logic   busy
);

  seq_state_t           state, state_next;
  logic [STEP_BITS-1:0] step, step_next;
  ctrl_t                ctrl_raw;
  logic                 take;

  assign ctrl_raw = ucode(step);

  always_comb begin
    unique case (ctrl_raw.cond)
      C_NONE:             take = 1'b0;
      C_ALWAYS:           take = 1'b1;
      C_SUM_LT_SIXTEENTH: take = flags.sum_lt_sixteenth;
      C_SUM_GE_FOUR:      take = flags.sum_ge_four;
      C_OUT_STRIP:        take = flags.out_strip;
      C_WB_LT_QCI2:       take = flags.wb_lt_qci2;
      C_N_AT_MAX:         take = flags.n_at_max;
      default:            take = 1'b0;
    endcase
  end

  always_comb begin
    state_next = state;
    step_next = step;
    unique case (state)
      ST_IDLE: begin
        if (start) begin
          state_next = ST_RUN;
          step_next = '0;
        end
      end
      ST_RUN: begin
        if (ctrl_raw.done) begin
          state_next = ST_IDLE;
        end else if (take) begin
          step_next = ctrl_raw.target;
        end else begin
          step_next = step + 1'b1;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    busy = (state == ST_RUN);
    ctrl = (state == ST_RUN) ? ctrl_raw : '0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      step <= '0;
    end else begin
      state <= state_next;
      step <= step_next;
    end
  end

endmodule

### design/mbe_datapath.sv
module mbe_datapath import mbe_pkg::*; #(
  parameter int INDEX_BITS = 12,
  parameter int FRAC_BITS = 28,
  parameter int ITER_BITS = 21
) (
  input  logic                     clk,
  input  logic                     accept,
  input  logic [INDEX_BITS-1:0]    column,
  input  logic [INDEX_BITS-1:0]    row,
  input  logic [STEP_REG_BITS-1:0] x_step,
  input  logic [STEP_REG_BITS-1:0] y_step,
  input  logic [ITER_BITS-1:0]     max_iter,
  input  ctrl_t                    ctrl,
  output flags_t                   flags,
  output logic [ITER_BITS-1:0]     n
);

  localparam int W = FRAC_BITS + 4;
  localparam int CPW = INDEX_BITS + STEP_REG_BITS;
  localparam int CW = (CPW > W) ? CPW : W;

  localparam logic signed [W-1:0] WMAX = {1'b0, {(W-1){1'b1}}};
  localparam logic signed [W-1:0] WMIN = {1'b1, {(W-1){1'b0}}};
  localparam logic signed [W+1:0] WMAX_X = {3'b000, {(W-1){1'b1}}};
  localparam logic signed [W+1:0] WMIN_X = {3'b111, {(W-1){1'b0}}};
  localparam logic signed [W-1:0] ONE = W'(1) << FRAC_BITS;
  localparam logic signed [W-1:0] QUARTER = W'(1) << (FRAC_BITS - 2);
  localparam logic signed [W-1:0] SIXTEENTH = W'(1) << (FRAC_BITS - 4);
  localparam logic signed [W-1:0] FOUR = W'(1) << (FRAC_BITS + 2);
  localparam logic signed [W-1:0] HALF = W'(1) << (FRAC_BITS - 1);
  localparam logic signed [W-1:0] NEG_3Q = -(W'(3) << (FRAC_BITS - 2));
  localparam logic signed [W-1:0] OFF_X = -(W'(1) << (FRAC_BITS + 1));
  localparam logic signed [W-1:0] OFF_Y = -(W'(9) << (FRAC_BITS - 3));
  localparam logic [CW-1:0] CMAX = CW'({1'b0, {(W-1){1'b1}}});

  logic [INDEX_BITS-1:0] col_q, row_q;
  logic signed [W-1:0]   cr, ci, ci2, zr, zi, zr2, zi2, p, t;
  logic [CPW-1:0]        cprod;
  logic [2*W-1:0]        prod;
  logic                  prod_neg;

  logic signed [W-1:0]   mul_a, mul_b, alu_a, alu_b;
  logic [W-1:0]          mag_a, mag_b;
  logic [W+3:0]          q, qr;
  logic                  big;
  logic signed [W-1:0]   mul_res;
  logic signed [W+1:0]   ax, bx, sx;
  logic signed [W-1:0]   alu_res;
  logic [CW-1:0]         cext;
  logic signed [W-1:0]   cval, coord;

  function automatic logic signed [W-1:0] pick(src_t s);
    logic signed [W-1:0] v;
    unique case (s)
      S_ONE:     v = ONE;
      S_QUARTER: v = QUARTER;
      S_CR:      v = cr;
      S_CI:      v = ci;
      S_CI2:     v = ci2;
      S_ZR:      v = zr;
      S_ZI:      v = zi;
      S_ZR2:     v = zr2;
      S_ZI2:     v = zi2;
      S_P:       v = p;
      S_T:       v = t;
      default:   v = '0;
    endcase
    return v;
  endfunction

  function automatic logic [W-1:0] mag(logic signed [W-1:0] x);
    return x[W-1] ? W'(-x) : W'(x);
  endfunction

  always_comb begin
    mul_a = pick(ctrl.mul_a);
    mul_b = pick(ctrl.mul_b);
    alu_a = pick(ctrl.alu_a);
    alu_b = pick(ctrl.alu_b);
    mag_a = mag(mul_a);
    mag_b = mag(mul_b);
  end

  always_comb begin
    q = prod[2*W-1:FRAC_BITS];
    qr = q + {{(W+3){1'b0}}, prod_neg & (|prod[FRAC_BITS-1:0])};
    big = |qr[W+3:W-1];
    if (!prod_neg) begin
      mul_res = big ? WMAX : $signed(qr[W-1:0]);
    end else begin
      mul_res = big ? WMIN : -$signed(qr[W-1:0]);
    end
  end

  always_comb begin
    ax = {{2{alu_a[W-1]}}, alu_a};
    bx = {{2{alu_b[W-1]}}, alu_b};
    sx = ctrl.alu_sub ? (ax - bx) : (ax + bx);
    if (sx > WMAX_X) begin
      alu_res = WMAX;
    end else if (sx < WMIN_X) begin
      alu_res = WMIN;
    end else begin
      alu_res = sx[W-1:0];
    end
  end

  always_comb begin
    cext = CW'(cprod);
    cval = (cext > CMAX) ? WMAX : $signed(cext[W-1:0]);
    coord = cval + (ctrl.cwb_y ? OFF_Y : OFF_X);
  end

  always_comb begin
    flags.sum_lt_sixteenth = (alu_res < SIXTEENTH);
    flags.sum_ge_four = (alu_res >= FOUR);
    flags.out_strip = !((cr > NEG_3Q) && (cr < HALF));
    flags.wb_lt_qci2 = (mul_res < (ci2 >>> 2));
    flags.n_at_max = (n >= max_iter);
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      col_q <= column;
      row_q <= row;
    end
    if (ctrl.cmul_en) begin
      cprod <= ctrl.cmul_y ? (CPW'(row_q) * CPW'(y_step)) : (CPW'(col_q) * CPW'(x_step));
    end
    if (ctrl.cwb_en) begin
      if (ctrl.cwb_y) begin
        ci <= coord;
      end else begin
        cr <= coord;
      end
    end
    if (ctrl.mul_en) begin
      prod <= {{W{1'b0}}, mag_a} * {{W{1'b0}}, mag_b};
      prod_neg <= mul_a[W-1] ^ mul_b[W-1];
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.wb_en) begin
      unique case (ctrl.wb_dst)
        D_CI2:   ci2 <= mul_res;
        D_ZR:    zr <= mul_res;
        D_ZI:    zi <= mul_res;
        D_ZR2:   zr2 <= mul_res;
        D_ZI2:   zi2 <= mul_res;
        D_P:     p <= mul_res;
        D_T:     t <= mul_res;
        default: t <= mul_res;
      endcase
    end
    if (ctrl.alu_en) begin
      unique case (ctrl.alu_dst)
        D_CI2:   ci2 <= alu_res;
        D_ZR:    zr <= alu_res;
        D_ZI:    zi <= alu_res;
        D_ZR2:   zr2 <= alu_res;
        D_ZI2:   zi2 <= alu_res;
        D_P:     p <= alu_res;
        D_T:     t <= alu_res;
        default: t <= alu_res;
      endcase
    end
    if (ctrl.zclr) begin
      zr <= '0;
      zi <= '0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.zclr) begin
      n <= '0;
    end else if (ctrl.ninc) begin
      n <= n + 1'b1;
    end
  end

endmodule
